[sv/clti_pkg.sv]
`timescale 1ns / 1ps
// Package for the clamped linear table interpolator: payload structs, codes,
// the command format passed from front to back and default parameters.
package clti_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int FRAC_BITS_DEF  = 16;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FEW   = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [9:0]         point_index;
		logic [31:0]        grid_radius;
		logic signed [31:0] grid_value;
		logic [31:0]        query_radius;
	} in_t;

	typedef struct packed {
		logic signed [31:0] interpolated_value;
		logic [1:0]         status;
	} out_t;

	// One command for the back end; radius holds the grid radius of a load
	// or the query radius of a query.
	typedef struct packed {
		logic        kind;
		logic [9:0]  point_index;
		logic [31:0] radius;
		logic [31:0] value;
	} cmd_t;

endpackage

[sv/clti_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, drops loads beyond the table and queues
// commands in a two-entry queue. Depends on clti_pkg.
module clti_front #(
	parameter int MAX_POINTS = clti_pkg::MAX_POINTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  clti_pkg::in_t  in_data,
	output logic           cmd_valid,
	input  logic           cmd_ready,
	output clti_pkg::cmd_t cmd
);
	import clti_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       keep;
	logic       do_wr;
	logic       do_rd;
	cmd_t       cmd_new;

	assign full = (count_q == 2'd2);
	// A load aimed past the end of the table is accepted and dropped here.
	assign keep = (in_data.kind == KIND_QUERY) || (32'(in_data.point_index) < MAX_POINTS);
	assign do_wr = push && !full && keep;
	assign cmd_valid = (count_q != 2'd0);
	assign do_rd = cmd_valid && cmd_ready;
	assign cmd = slot_q[rd_ptr_q];

	always_comb begin
		cmd_new.kind = in_data.kind;
		cmd_new.point_index = in_data.point_index;
		cmd_new.radius = (in_data.kind == KIND_QUERY) ? in_data.query_radius
			: in_data.grid_radius;
		cmd_new.value = in_data.grid_value;
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

endmodule

[sv/clti_back.sv]
`timescale 1ns / 1ps
// Back end: grid tables, order check, binary search, serial divider,
// multiply and the result register. Depends on clti_pkg.
module clti_back #(
	parameter int MAX_POINTS = clti_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = clti_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [10:0]    point_count,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  clti_pkg::cmd_t cmd,
	output logic           empty,
	input  logic           pop,
	output clti_pkg::out_t out_data
);
	import clti_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int FW = FRAC_BITS + 1;
	localparam int DCW = $clog2(FRAC_BITS + 1);
	localparam int PW = FW + 34;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LDRD = 4'd1;
	localparam logic [3:0] S_LDWR = 4'd2;
	localparam logic [3:0] S_RD0  = 4'd3;
	localparam logic [3:0] S_RDN  = 4'd4;
	localparam logic [3:0] S_CHKN = 4'd5;
	localparam logic [3:0] S_SISS = 4'd6;
	localparam logic [3:0] S_SCMP = 4'd7;
	localparam logic [3:0] S_SEG0 = 4'd8;
	localparam logic [3:0] S_SEG1 = 4'd9;
	localparam logic [3:0] S_SEG2 = 4'd10;
	localparam logic [3:0] S_DSET = 4'd11;
	localparam logic [3:0] S_DIV  = 4'd12;
	localparam logic [3:0] S_MUL  = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;
	localparam logic [3:0] S_PUSH = 4'd15;

	logic [31:0] radius_mem [MAX_POINTS];
	logic [31:0] value_mem  [MAX_POINTS];

	logic [3:0]          state_q;
	cmd_t                cmd_q;
	logic                order_err_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       mid_q;
	logic [31:0]         rd_radius_q;
	logic [31:0]         rd_value_q;
	logic [31:0]         r0_q;
	logic [31:0]         r1_q;
	logic [31:0]         v0_q;
	logic [31:0]         v1_q;
	logic [31:0]         rem_q;
	logic [31:0]         den_q;
	logic [FW-1:0]       frac_q;
	logic [DCW-1:0]      dcnt_q;
	logic signed [PW-1:0] prod_q;
	out_t                res_q;
	out_t                out_q;
	logic                out_valid_q;

	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  ld_addr;
	logic           we;
	logic [31:0]    cnt32;
	logic [CW-1:0]  n_clamp;
	logic [CW-1:0]  mid;
	logic [CW-1:0]  lo_c;
	logic [32:0]    rem_sh;
	logic [32:0]    rem_sub;
	logic signed [32:0] vdiff;
	logic [31:0]    num;
	logic signed [PW-1:0] frac_ext;
	logic signed [PW-1:0] vdiff_ext;

	assign cnt32 = 32'(point_count);
	assign n_clamp = (cnt32 > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(cnt32);
	assign ld_addr = AW'(cmd_q.point_index);
	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign lo_c = (lo_q == '0) ? CW'(1) : ((lo_q > n_q - CW'(1)) ? n_q - CW'(1) : lo_q);
	assign rem_sh = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign vdiff = $signed({v1_q[31], v1_q}) - $signed({v0_q[31], v0_q});
	assign num = cmd_q.radius - r0_q;
	// Both factors widened to the product width so no bits are lost.
	assign frac_ext = $signed({{(PW-FW){1'b0}}, frac_q});
	assign vdiff_ext = $signed({{(PW-33){vdiff[32]}}, vdiff});

	assign cmd_ready = (state_q == S_IDLE);
	assign empty = !out_valid_q;
	assign out_data = out_q;

	always_comb begin
		rd_addr = '0;
		we = 1'b0;
		unique case (state_q)
			S_LDRD: begin
				rd_addr = AW'(cmd_q.point_index - 10'd1);
				we = (cmd_q.point_index == 10'd0);
			end
			S_LDWR: we = 1'b1;
			S_RD0:  rd_addr = '0;
			S_RDN:  rd_addr = AW'(n_q - CW'(1));
			S_SISS: rd_addr = mid[AW-1:0];
			S_SEG0: rd_addr = AW'(lo_c - CW'(1));
			S_SEG1: rd_addr = lo_q[AW-1:0];
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			radius_mem[ld_addr] <= cmd_q.radius;
			value_mem[ld_addr] <= cmd_q.value;
		end
		rd_radius_q <= radius_mem[rd_addr];
		rd_value_q <= value_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			order_err_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= (cmd.kind == KIND_LOAD) ? S_LDRD : S_RD0;
					end
				end
				S_LDRD: begin
					if (cmd_q.point_index == 10'd0) begin
						order_err_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LDWR;
					end
				end
				S_LDWR: begin
					if (!(cmd_q.radius > rd_radius_q)) order_err_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD0: begin
					if (n_q < CW'(2)) state_q <= S_PUSH;
					else if (order_err_q) state_q <= S_PUSH;
					else state_q <= S_RDN;
				end
				S_RDN:  state_q <= (cmd_q.radius <= rd_radius_q) ? S_PUSH : S_CHKN;
				S_CHKN: state_q <= (cmd_q.radius >= rd_radius_q) ? S_PUSH : S_SISS;
				S_SISS: state_q <= (lo_q < hi_q) ? S_SCMP : S_SEG0;
				S_SCMP: state_q <= S_SISS;
				S_SEG0: state_q <= S_SEG1;
				S_SEG1: state_q <= S_SEG2;
				S_SEG2: state_q <= S_DSET;
				S_DSET: begin
					if (r1_q <= r0_q || cmd_q.radius < r0_q || num >= r1_q - r0_q) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV:  if (dcnt_q == DCW'(1)) state_q <= S_MUL;
				S_MUL:  state_q <= S_FIN;
				S_FIN:  state_q <= S_PUSH;
				S_PUSH: begin
					if (!out_valid_q || pop) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// A new result replaces the one being popped in the same cycle.
			if (state_q == S_PUSH && (!out_valid_q || pop)) out_valid_q <= 1'b1;
			else if (pop && out_valid_q) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q <= cmd;
				n_q <= n_clamp;
			end
			S_RD0: begin
				res_q.interpolated_value <= '0;
				res_q.status <= (n_q < CW'(2)) ? ST_FEW : ST_ORDER;
			end
			S_RDN: begin
				res_q.interpolated_value <= rd_value_q;
				res_q.status <= ST_OK;
			end
			S_CHKN: begin
				res_q.interpolated_value <= rd_value_q;
				res_q.status <= ST_OK;
				lo_q <= '0;
				hi_q <= n_q;
			end
			S_SISS: mid_q <= mid;
			S_SCMP: begin
				if (rd_radius_q <= cmd_q.radius) lo_q <= mid_q + CW'(1);
				else hi_q <= mid_q;
			end
			S_SEG0: lo_q <= lo_c;
			S_SEG1: begin
				r0_q <= rd_radius_q;
				v0_q <= rd_value_q;
			end
			S_SEG2: begin
				r1_q <= rd_radius_q;
				v1_q <= rd_value_q;
			end
			S_DSET: begin
				rem_q <= num;
				den_q <= r1_q - r0_q;
				dcnt_q <= DCW'(FRAC_BITS);
				if (r1_q <= r0_q || cmd_q.radius < r0_q) frac_q <= '0;
				else if (num >= r1_q - r0_q) frac_q <= FW'(1) << FRAC_BITS;
				else frac_q <= '0;
			end
			S_DIV: begin
				// Restoring division, one quotient bit per cycle.
				dcnt_q <= dcnt_q - DCW'(1);
				if (!rem_sub[32]) begin
					rem_q <= rem_sub[31:0];
					frac_q <= {frac_q[FW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					frac_q <= {frac_q[FW-2:0], 1'b0};
				end
			end
			S_MUL: prod_q <= frac_ext * vdiff_ext;
			S_FIN: begin
				// Arithmetic shift of the product floors toward minus infinity.
				res_q.interpolated_value <= v0_q + prod_q[FRAC_BITS+31:FRAC_BITS];
				res_q.status <= ST_OK;
			end
			S_PUSH: if (!out_valid_q || pop) out_q <= res_q;
			default: ;
		endcase
	end

endmodule

[sv/clamped_linear_table_interpolator_unit.sv]
`timescale 1ns / 1ps
// Top level of the clamped linear table interpolator: configuration register,
// front end and back end. Depends on clti_pkg, clti_front and clti_back.
//
// This unit stores up to MAX_POINTS radius/value pairs in Q16.16 and answers
// queries by piecewise-linear interpolation, clamping to the first and last
// value outside the grid. Requests enter through a queue-style port (push,
// full) and land in a two-entry command queue, so the requester can keep
// pushing while the back end works; results leave through a one-entry
// result register (empty, pop), and the back end starts on the next request
// while a finished result waits. A load passes through the accept state, a
// table read for the ordering check and then the write; at index 0 the write
// happens in the read state instead. A query runs each binary-search step as
// a read state and a compare state, set by the registered read of the single
// table read port, and then runs the serial divider, which yields one
// fraction bit per iteration. A query that clamps at either end, or that
// finds fewer than two points or an out-of-order grid, skips the search and
// the divider. The point count register lies at byte address 0 and must be
// written only while the unit is idle. The tables are undefined after reset
// until loaded.
module clamped_linear_table_interpolator_unit #(
	parameter int MAX_POINTS = clti_pkg::MAX_POINTS_DEF,
	parameter int FRAC_BITS  = clti_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  clti_pkg::in_t  in_data,
	output logic           empty,
	input  logic           pop,
	output clti_pkg::out_t out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import clti_pkg::*;

	logic [10:0] point_count_q;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;

	// Register 0 is the only register; bit 2 of the address selects beyond it.
	assign pready = 1'b1;
	assign prdata = (!paddr[2]) ? {21'd0, point_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			point_count_q <= pwdata[10:0];
		end
	end

	clti_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_data(in_data),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd)
	);

	clti_back #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.point_count(point_count_q),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.empty(empty),
		.pop(pop),
		.out_data(out_data)
	);

endmodule

[sv/clti_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the interpolator unit and the bind that attaches
// them. Depends on clti_pkg and clamped_linear_table_interpolator_unit.
module clti_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input logic           pready,
	input clti_pkg::out_t out_data
);
	import clti_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_data.status == ST_OK || out_data.status == ST_FEW
			|| out_data.status == ST_ORDER))
		else $error("result status code out of range");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_data.status != ST_OK) |-> (out_data.interpolated_value == 32'sd0))
		else $error("error result carries a nonzero value");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_data)))
		else $error("waiting result changed or vanished");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port not ready");

endmodule

bind clamped_linear_table_interpolator_unit clti_checker u_clti_checker (
	.clk(clk),
	.arst_n(arst_n),
	.empty(empty),
	.pop(pop),
	.pready(pready),
	.out_data(out_data)
);
